// ===== sv/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and the 8x8 scale helper for the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // hue steps per colour wheel sector
  localparam int unsigned SectorSteps = 43;
  // ramp slope within one sector
  localparam int unsigned RampGain    = 6;

  localparam logic [7:0] Sector1Base = 8'(SectorSteps * 1);
  localparam logic [7:0] Sector2Base = 8'(SectorSteps * 2);
  localparam logic [7:0] Sector3Base = 8'(SectorSteps * 3);
  localparam logic [7:0] Sector4Base = 8'(SectorSteps * 4);
  localparam logic [7:0] Sector5Base = 8'(SectorSteps * 5);

  // largest ramp value, at the last step of a sector
  localparam logic [7:0] RampMax = 8'((SectorSteps - 1) * RampGain);

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_e;

  // 8x8 product, top byte kept
  function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] prod;
    prod = a * b;
    return prod[15:8];
  endfunction

endpackage

// ===== sv/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts 8-bit hue, saturation and value words into 8-bit red, green, blue.
// ----------------------------------------------------------------------------
// usage
//   input channel : in_valid_i / in_stall_o, payload hue_i, saturation_i,
//                   brightness_i; a word is taken on a rising edge with
//                   in_valid_i high and in_stall_o low
//   output channel: out_valid_o / out_stall_i, payload red_o, green_o, blue_o;
//                   one result word for every input word, in order
//   path          : an accepted word passes four registers in order, stage 1,
//                   stage 2, stage 3 and the output register behind out_valid_o
//   throughput    : one word per cycle while out_stall_i is low, set by the four
//                   register stages (sector split, first scale products, blend
//                   and second scale products, channel select), each taking a
//                   new word every cycle unless held
//   stall         : a stage holds while the stage after it is full and held;
//                   empty stages keep filling, so up to four words are held
//                   inside while out_stall_i is high, and nothing is lost or
//                   repeated
//   reset         : rst_ni clears all valid bits; the pipeline comes up empty
//                   and ready for input
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input word
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] hue_i,
  input  logic [7:0] saturation_i,
  input  logic [7:0] brightness_i,
  // output word
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage moves when it is empty or its successor
  // moves; the output register moves when the receiver does not stall
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_en, s2_en, s3_en, out_en;

  assign out_en = !out_valid_q || !out_stall_i;
  assign s3_en  = !s3_valid_q  || out_en;
  assign s2_en  = !s2_valid_q  || s3_en;
  assign s1_en  = !s1_valid_q  || s2_en;

  assign in_stall_o = !s1_en;

  // --------------------------------------------------------------------------
  // stage 1: sector split of the hue, ramp within the sector, inverted
  // saturation
  // --------------------------------------------------------------------------
  hsv2rgb_pkg::sector_e sector_d;
  logic [7:0]           sector_base;
  logic [7:0]           remainder;
  logic [7:0]           ramp_d;

  always_comb begin
    if (hue_i >= hsv2rgb_pkg::Sector5Base) begin
      sector_d    = hsv2rgb_pkg::SECTOR_5;
      sector_base = hsv2rgb_pkg::Sector5Base;
    end else if (hue_i >= hsv2rgb_pkg::Sector4Base) begin
      sector_d    = hsv2rgb_pkg::SECTOR_4;
      sector_base = hsv2rgb_pkg::Sector4Base;
    end else if (hue_i >= hsv2rgb_pkg::Sector3Base) begin
      sector_d    = hsv2rgb_pkg::SECTOR_3;
      sector_base = hsv2rgb_pkg::Sector3Base;
    end else if (hue_i >= hsv2rgb_pkg::Sector2Base) begin
      sector_d    = hsv2rgb_pkg::SECTOR_2;
      sector_base = hsv2rgb_pkg::Sector2Base;
    end else if (hue_i >= hsv2rgb_pkg::Sector1Base) begin
      sector_d    = hsv2rgb_pkg::SECTOR_1;
      sector_base = hsv2rgb_pkg::Sector1Base;
    end else begin
      sector_d    = hsv2rgb_pkg::SECTOR_0;
      sector_base = 8'd0;
    end
  end

  // remainder stays below 43, so six times it fits in a byte
  assign remainder = hue_i - sector_base;
  assign ramp_d    = 8'(remainder * 8'(hsv2rgb_pkg::RampGain));

  hsv2rgb_pkg::sector_e s1_sector_q;
  logic [7:0]           s1_ramp_q;
  logic [7:0]           s1_inv_sat_q;
  logic [7:0]           s1_bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_sector_q  <= sector_d;
      s1_ramp_q    <= ramp_d;
      s1_inv_sat_q <= ~saturation_i;
      s1_bright_q  <= brightness_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: first scale products (low channel, blend corrections)
  // --------------------------------------------------------------------------
  hsv2rgb_pkg::sector_e s2_sector_q;
  logic [7:0]           s2_ramp_q;
  logic [7:0]           s2_bright_q;
  logic [7:0]           s2_low_q;
  logic [7:0]           s2_nr_is_q;    // (255 - ramp) scaled by inverted sat
  logic [7:0]           s2_ramp_is_q;  // ramp scaled by inverted sat

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_sector_q  <= s1_sector_q;
      s2_ramp_q    <= s1_ramp_q;
      s2_bright_q  <= s1_bright_q;
      s2_low_q     <= hsv2rgb_pkg::mul8(s1_inv_sat_q, s1_bright_q);
      s2_nr_is_q   <= hsv2rgb_pkg::mul8(~s1_ramp_q, s1_inv_sat_q);
      s2_ramp_is_q <= hsv2rgb_pkg::mul8(s1_ramp_q, s1_inv_sat_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: rising and falling blends, scaled by the brightness
  // --------------------------------------------------------------------------
  logic [7:0] up_blend;
  logic [7:0] down_blend;

  // neither sum passes 255, the top byte of each product keeps it in range
  assign up_blend   = s2_ramp_q + s2_nr_is_q;
  assign down_blend = ~s2_ramp_q + s2_ramp_is_q;

  hsv2rgb_pkg::sector_e s3_sector_q;
  logic [7:0]           s3_full_q;
  logic [7:0]           s3_low_q;
  logic [7:0]           s3_up_q;
  logic [7:0]           s3_down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_valid_q) begin
      s3_sector_q <= s2_sector_q;
      s3_full_q   <= s2_bright_q;
      s3_low_q    <= s2_low_q;
      s3_up_q     <= hsv2rgb_pkg::mul8(up_blend, s2_bright_q);
      s3_down_q   <= hsv2rgb_pkg::mul8(down_blend, s2_bright_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: route the four channel terms by sector into the output register
  // --------------------------------------------------------------------------
  logic [7:0] red_d, green_d, blue_d;

  always_comb begin
    unique case (s3_sector_q)
      hsv2rgb_pkg::SECTOR_0: begin
        red_d = s3_full_q; green_d = s3_up_q;   blue_d = s3_low_q;
      end
      hsv2rgb_pkg::SECTOR_1: begin
        red_d = s3_down_q; green_d = s3_full_q; blue_d = s3_low_q;
      end
      hsv2rgb_pkg::SECTOR_2: begin
        red_d = s3_low_q;  green_d = s3_full_q; blue_d = s3_up_q;
      end
      hsv2rgb_pkg::SECTOR_3: begin
        red_d = s3_low_q;  green_d = s3_down_q; blue_d = s3_full_q;
      end
      hsv2rgb_pkg::SECTOR_4: begin
        red_d = s3_up_q;   green_d = s3_low_q;  blue_d = s3_full_q;
      end
      default: begin
        red_d = s3_full_q; green_d = s3_low_q;  blue_d = s3_down_q;
      end
    endcase
  end

  logic [7:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s3_valid_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // an accepted word always lands in stage 1
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted word did not enter stage 1");

  // the ramp never passes its value at the last step of a sector
  a_ramp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_ramp_q <= hsv2rgb_pkg::RampMax))
    else $error("ramp out of range");

  // blend sums never wrap
  a_blend_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (({1'b0, s2_ramp_q} + {1'b0, s2_nr_is_q} <= 9'd255) &&
                    ({1'b0, ~s2_ramp_q} + {1'b0, s2_ramp_is_q} <= 9'd255)))
    else $error("blend sum overflow");

  // a full last stage moves on when the output register frees up
  a_stage3_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && out_en) |=> out_valid_q)
    else $error("stage 3 word dropped");

  // a held output word is never overwritten by the stage behind it
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(red_q) &&
                                      $stable(green_q) && $stable(blue_q)))
    else $error("stalled output word changed");

endmodule
